@@ src/gbs_pkg.sv @@
// ============================================================================
// gbs_pkg
// shared types, constants and helpers of the greedy box suppression unit
// ============================================================================
package gbs_pkg;

    localparam int MAX_KEPT   = 64;
    localparam int COORD_BITS = 16;

    localparam int CW      = COORD_BITS;
    localparam int EW      = CW + 1;
    localparam int AW      = 2 * CW;
    localparam int THR_W   = 16;
    localparam int IDX_W   = 16;
    localparam int CNT_W   = $clog2(MAX_KEPT + 1);
    localparam int ADDR_W  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int UH_W    = AW + 1 - THR_W;
    localparam int PH_W    = THR_W + UH_W;
    localparam int Q_W     = PH_W + 1;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(29491);
    localparam logic [IDX_W-1:0] IDX_MAX   = {IDX_W{1'b1}};

    typedef struct packed {
        logic          frame_start;
        logic [EW-1:0] left;
        logic [EW-1:0] top;
        logic [EW-1:0] right;
        logic [EW-1:0] bottom;
        logic [AW-1:0] area;
        logic [IDX_W-1:0] index;
    } job_t;

    typedef struct packed {
        logic [EW-1:0] left;
        logic [EW-1:0] top;
        logic [EW-1:0] right;
        logic [EW-1:0] bottom;
        logic [AW-1:0] area;
    } kept_t;

    localparam int ENTRY_W = $bits(kept_t);

    typedef struct packed {
        logic             keep;
        logic [IDX_W-1:0] index;
        logic             full;
    } result_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_DONE
    } back_state_t;

    // overlap of two intervals, zero when disjoint or touching
    function automatic logic [CW-1:0] span(
        input logic [EW-1:0] lo_a,
        input logic [EW-1:0] hi_a,
        input logic [EW-1:0] lo_b,
        input logic [EW-1:0] hi_b
    );
        logic [EW-1:0] lo;
        logic [EW-1:0] hi;
        logic [EW-1:0] diff;
        lo   = (lo_a > lo_b) ? lo_a : lo_b;
        hi   = (hi_a < hi_b) ? hi_a : hi_b;
        diff = hi - lo;
        return (hi > lo) ? diff[CW-1:0] : '0;
    endfunction

endpackage

@@ src/gbs_ram.sv @@
// ============================================================================
// gbs_ram
// generic single write port, single read port ram with registered read
// ============================================================================
module gbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/gbs_front.sv @@
// ============================================================================
// gbs_front
// input stage: takes boxes, derives edges and area, numbers them in the frame
// ============================================================================
module gbs_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    frame_start,
    input  logic [15:0]             box_left,
    input  logic [15:0]             box_top,
    input  logic [15:0]             box_width,
    input  logic [15:0]             box_height,
    output logic                    job_valid,
    input  logic                    job_ready,
    output gbs_pkg::job_t           job
);
    import gbs_pkg::*;

    logic             hold_valid_reg;
    logic             hold_valid_next;
    job_t             job_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic [IDX_W-1:0] base;
    logic             accept;
    logic [CW-1:0]    left;
    logic [CW-1:0]    top;
    logic [CW-1:0]    w;
    logic [CW-1:0]    h;

    assign full   = hold_valid_reg && !job_ready;
    assign accept = push && !full;

    assign left = CW'(box_left);
    assign top  = CW'(box_top);
    assign w    = CW'(box_width);
    assign h    = CW'(box_height);

    assign base = frame_start ? '0 : cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = (base == IDX_MAX) ? base : base + IDX_W'(1);
        end
    end

    assign hold_valid_next = accept || (hold_valid_reg && !job_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg.frame_start <= frame_start;
            job_reg.left        <= {1'b0, left};
            job_reg.top         <= {1'b0, top};
            job_reg.right       <= {1'b0, left} + {1'b0, w};
            job_reg.bottom      <= {1'b0, top} + {1'b0, h};
            job_reg.area        <= AW'(w) * AW'(h);
            job_reg.index       <= base;
        end
    end

    assign job_valid = hold_valid_reg;
    assign job       = job_reg;

endmodule

@@ src/gbs_queue.sv @@
// ============================================================================
// gbs_queue
// two-entry queue between the input stage and the suppression engine
// ============================================================================
module gbs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  gbs_pkg::job_t  in_job,
    output logic           out_valid,
    input  logic           out_pop,
    output gbs_pkg::job_t  out_job
);
    import gbs_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg;
    logic [QPTR_W-1:0] rp_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              wr;
    logic              rd;

    assign in_ready  = (cnt_reg != QCNT_W'(QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign wr        = in_valid && in_ready;
    assign rd        = out_pop && out_valid;
    assign out_job   = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= wp_reg + QPTR_W'(1);
            end
            if (rd)
            begin
                rp_reg <= rp_reg + QPTR_W'(1);
            end
            if (wr && !rd)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (rd && !wr)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= in_job;
        end
    end

endmodule

@@ src/gbs_back.sv @@
// ============================================================================
// gbs_back
// suppression engine: scans the picked-box table, one entry per cycle
// ============================================================================
module gbs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gbs_pkg::THR_W-1:0]     threshold,
    input  logic                          job_valid,
    output logic                          job_pop,
    input  gbs_pkg::job_t                 job,
    output logic                          res_valid,
    input  logic                          res_pop,
    output gbs_pkg::result_t              result
);
    import gbs_pkg::*;

    back_state_t      state_reg;
    back_state_t      state_next;
    job_t             cur_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] scan_reg;
    logic [CNT_W-1:0] scan_next;
    logic             supp_reg;
    logic             supp_next;
    logic [4:0]       valid_reg;
    logic             res_valid_reg;
    logic             res_valid_next;
    result_t          result_reg;

    logic             issue;
    logic             finish;
    logic             keep;
    logic             store;
    logic             exceed;

    logic [ENTRY_W-1:0] rd_data;
    kept_t              entry;
    kept_t              new_entry;

    logic [CW-1:0]    iw_reg;
    logic [CW-1:0]    ih_reg;
    logic [AW-1:0]    ka_reg;
    logic [AW-1:0]    inter2_reg;
    logic [AW:0]      sum_reg;
    logic [AW-1:0]    inter3_reg;
    logic [AW:0]      uni_reg;
    logic [AW-1:0]    inter4_reg;
    logic [PH_W-1:0]  ph_reg;
    logic [2*THR_W-1:0] pl_reg;
    logic [Q_W-1:0]   q;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (scan_reg == count_reg)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (valid_reg == '0)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!res_valid_reg || res_pop)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        job_pop = 1'b0;
        issue   = 1'b0;
        finish  = 1'b0;
        unique case (state_reg)
            BK_IDLE:  job_pop = job_valid;
            BK_SCAN:  issue   = (scan_reg != count_reg);
            BK_DRAIN: ;
            BK_DONE:  finish  = !res_valid_reg || res_pop;
            default:  ;
        endcase
    end

    assign keep  = !supp_reg;
    assign store = keep && (count_reg != CNT_W'(MAX_KEPT));

    always_comb
    begin
        count_next = count_reg;
        scan_next  = scan_reg;
        supp_next  = supp_reg;
        if (job_pop)
        begin
            count_next = job.frame_start ? '0 : count_reg;
            scan_next  = '0;
            supp_next  = 1'b0;
        end
        else
        begin
            if (issue)
            begin
                scan_next = scan_reg + CNT_W'(1);
            end
            if (valid_reg[4] && exceed)
            begin
                supp_next = 1'b1;
            end
            if (finish && store)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (finish)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            supp_reg      <= 1'b0;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            supp_reg      <= supp_next;
            valid_reg     <= {valid_reg[3:0], issue};
            res_valid_reg <= res_valid_next;
        end
    end

    // picked-box table
    assign new_entry.left   = cur_reg.left;
    assign new_entry.top    = cur_reg.top;
    assign new_entry.right  = cur_reg.right;
    assign new_entry.bottom = cur_reg.bottom;
    assign new_entry.area   = cur_reg.area;

    gbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEPT)
    ) u_table (
        .clk     (clk),
        .wr_en   (finish && store),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (new_entry),
        .rd_en   (issue),
        .rd_addr (scan_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign entry = kept_t'(rd_data);

    // overlap pipeline
    assign q      = Q_W'(ph_reg) + Q_W'(pl_reg[2*THR_W-1:THR_W]);
    assign exceed = (Q_W'(inter4_reg) > q);

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            cur_reg <= job;
        end
        iw_reg     <= span(cur_reg.left, cur_reg.right, entry.left, entry.right);
        ih_reg     <= span(cur_reg.top, cur_reg.bottom, entry.top, entry.bottom);
        ka_reg     <= entry.area;
        inter2_reg <= AW'(iw_reg) * AW'(ih_reg);
        sum_reg    <= {1'b0, cur_reg.area} + {1'b0, ka_reg};
        inter3_reg <= inter2_reg;
        uni_reg    <= sum_reg - {1'b0, inter2_reg};
        inter4_reg <= inter3_reg;
        ph_reg     <= PH_W'(threshold) * PH_W'(uni_reg[AW:THR_W]);
        pl_reg     <= (2*THR_W)'(threshold) * (2*THR_W)'(uni_reg[THR_W-1:0]);
        if (finish)
        begin
            result_reg.keep  <= keep;
            result_reg.index <= cur_reg.index;
            result_reg.full  <= keep && !store;
        end
    end

    assign res_valid = res_valid_reg;
    assign result    = result_reg;

endmodule

@@ src/greedy_box_suppression_unit.sv @@
// ============================================================================
// greedy_box_suppression_unit
// greedy non-maximum suppression of score-sorted boxes by overlap ratio
// ============================================================================
// Boxes enter through a queue-style port and each produces one result, in
// order. Taken from the head of the internal queue, a box is compared with
// the N boxes picked so far in the frame (at most 64): the engine reads one
// picked box per cycle from the table ram and runs it through the overlap
// pipeline, then drains and writes back. On its way in, a box is registered
// in the input stage and then passes through the queue. A result that is
// not popped holds the engine before its next box. An input stage and a
// two-entry queue keep accepting boxes while the engine works or while a
// result waits to be popped.
// ============================================================================
module greedy_box_suppression_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        frame_start,
    input  logic [15:0] box_left,
    input  logic [15:0] box_top,
    input  logic [15:0] box_width,
    input  logic [15:0] box_height,
    output logic        empty,
    input  logic        pop,
    output logic        keep,
    output logic [15:0] box_index,
    output logic        table_full,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] iou_threshold
);
    import gbs_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic             f_valid;
    logic             f_ready;
    job_t             f_job;
    logic             b_valid;
    logic             b_pop;
    job_t             b_job;
    logic             res_valid;
    result_t          result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= iou_threshold;
        end
    end

    gbs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .frame_start (frame_start),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_width   (box_width),
        .box_height  (box_height),
        .job_valid   (f_valid),
        .job_ready   (f_ready),
        .job         (f_job)
    );

    gbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_job    (f_job),
        .out_valid (b_valid),
        .out_pop   (b_pop),
        .out_job   (b_job)
    );

    gbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (thr_reg),
        .job_valid (b_valid),
        .job_pop   (b_pop),
        .job       (b_job),
        .res_valid (res_valid),
        .res_pop   (pop),
        .result    (result)
    );

    assign empty      = !res_valid;
    assign keep       = result.keep;
    assign box_index  = result.index;
    assign table_full = result.full;

endmodule

@@ src/gbs_checker.sv @@
// ============================================================================
// gbs_port_checks
// port-level checks of the greedy box suppression unit
// ============================================================================
module gbs_port_checks (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        empty,
    input  logic        pop,
    input  logic        keep,
    input  logic [15:0] box_index,
    input  logic        table_full
);

    // a waiting result beat holds until popped
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(box_index) && $stable(keep)
                              && $stable(table_full)))
        else $error("result changed while stalled");

    // table overflow is only flagged on kept boxes
    a_full_needs_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && table_full) |-> keep)
        else $error("table_full on suppressed box");

    // input side cannot become full without a new beat
    a_full_only_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        (!push && !full) |=> !full)
        else $error("full rose without push");

endmodule

bind greedy_box_suppression_unit gbs_port_checks u_port_checks (.*);

@@ sim/gbs_checker.sv @@
// ============================================================================
// gbs_checker
// beat monitor and result predictor for the greedy box suppression unit
// ============================================================================
// Watches the box, result and threshold channels. It keeps its own copy of
// the picked-box table, the frame index and the threshold. For every box beat
// it works out the verdict and queues it. Each result beat is compared field
// by field against the oldest queued verdict.
// ============================================================================
module gbs_checker
    import gbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        frame_start,
    input  logic [15:0] box_left,
    input  logic [15:0] box_top,
    input  logic [15:0] box_width,
    input  logic [15:0] box_height,
    input  logic        empty,
    input  logic        pop,
    input  logic        keep,
    input  logic [15:0] box_index,
    input  logic        table_full,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] iou_threshold,
    output int          mismatch_count,
    output int          results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [16:0]      pick_left  [MAX_KEPT];
    logic [16:0]      pick_top   [MAX_KEPT];
    logic [16:0]      pick_right [MAX_KEPT];
    logic [16:0]      pick_bottom[MAX_KEPT];
    logic [31:0]      pick_area  [MAX_KEPT];
    int               picked_n   = 0;
    logic [IDX_W-1:0] frame_pos  = '0;
    logic [THR_W-1:0] overlap_thr = THR_RESET;
    result_t          verdict_q[$];
    result_t          want;
    result_t          verdict;

    task automatic report_mismatch(input string what, input longint got, input longint wanted);
        if (mismatch_count < 200)
            $display("%0t gbs_checker: %s got %0d want %0d", $time, what, got, wanted);
        mismatch_count++;
    endtask

    function automatic result_t judge_box(
        input logic        fs,
        input logic [15:0] l16,
        input logic [15:0] t16,
        input logic [15:0] w16,
        input logic [15:0] h16
    );
        result_t     res;
        logic [16:0] l;
        logic [16:0] t;
        logic [16:0] r;
        logic [16:0] b;
        logic [16:0] lo;
        logic [16:0] hi;
        logic [15:0] iw;
        logic [15:0] ih;
        logic [31:0] area;
        logic [31:0] inter;
        logic [32:0] uni;
        l    = {1'b0, l16};
        t    = {1'b0, t16};
        r    = l + w16;
        b    = t + h16;
        area = 32'(w16) * 32'(h16);
        if (fs)
        begin
            picked_n  = 0;
            frame_pos = '0;
        end
        res.index = frame_pos;
        if (frame_pos != IDX_MAX)
            frame_pos++;
        res.keep = 1'b1;
        res.full = 1'b0;
        for (int j = 0; j < picked_n; j++)
        begin
            lo    = (l > pick_left[j]) ? l : pick_left[j];
            hi    = (r < pick_right[j]) ? r : pick_right[j];
            iw    = (hi > lo) ? 16'(hi - lo) : 16'd0;
            lo    = (t > pick_top[j]) ? t : pick_top[j];
            hi    = (b < pick_bottom[j]) ? b : pick_bottom[j];
            ih    = (hi > lo) ? 16'(hi - lo) : 16'd0;
            inter = 32'(iw) * 32'(ih);
            uni   = 33'(area) + 33'(pick_area[j]) - 33'(inter);
            if ((64'(inter) << 16) > 64'(overlap_thr) * 64'(uni))
                res.keep = 1'b0;
        end
        if (res.keep)
        begin
            if (picked_n < MAX_KEPT)
            begin
                pick_left[picked_n]   = l;
                pick_top[picked_n]    = t;
                pick_right[picked_n]  = r;
                pick_bottom[picked_n] = b;
                pick_area[picked_n]   = area;
                picked_n++;
            end
            else
            begin
                res.full = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            picked_n       = 0;
            frame_pos      = '0;
            overlap_thr    = THR_RESET;
            mismatch_count = 0;
            verdict_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                overlap_thr = iou_threshold;
            if (pop && !empty)
            begin
                if (verdict_q.size() == 0)
                begin
                    report_mismatch("result beat with nothing pending, index", box_index, 0);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (keep !== want.keep)
                        report_mismatch("keep", keep, want.keep);
                    if (box_index !== want.index)
                        report_mismatch("box_index", box_index, want.index);
                    if (table_full !== want.full)
                        report_mismatch("table_full", table_full, want.full);
                end
            end
            if (push && !full)
            begin
                verdict   = judge_box(frame_start, box_left, box_top,
                                      box_width, box_height);
                verdict_q = {verdict_q, verdict};
            end
        end
        results_owed <= verdict_q.size();
    end

endmodule

@@ sim/tb_top.sv @@
// ============================================================================
// tb_top
// testbench of the greedy box suppression unit
// ============================================================================
// Directed boxes hit empty and full-size boxes, touching and identical boxes
// and the threshold extremes. Random frames of clustered boxes follow under
// three idling mixes, with table-filling frames and a long result hold-off.
// gbs_checker predicts and compares every result beat.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        push          = 1'b0;
    logic        full;
    logic        frame_start   = 1'b0;
    logic [15:0] box_left      = '0;
    logic [15:0] box_top       = '0;
    logic [15:0] box_width     = '0;
    logic [15:0] box_height    = '0;
    logic        empty;
    logic        pop           = 1'b0;
    logic        keep;
    logic [15:0] box_index;
    logic        table_full;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] iou_threshold = '0;
    int          mismatch_count;
    int          results_owed;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int boxes_sent    = 0;
    int hold_reqs     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;

    greedy_box_suppression_unit DUT (.*);
    gbs_checker u_checker (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result side
    always @(posedge clk)
    begin
        if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    task automatic offer_box(
        input logic        fs,
        input logic [15:0] l,
        input logic [15:0] t,
        input logic [15:0] w,
        input logic [15:0] h
    );
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        frame_start <= fs;
        box_left    <= l;
        box_top     <= t;
        box_width   <= w;
        box_height  <= h;
        @(posedge clk);
        while (full)
            @(posedge clk);
        boxes_sent++;
    endtask

    task automatic wait_all_results;
        push <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    task automatic set_threshold(input logic [15:0] v);
        cfg_valid     <= 1'b1;
        iou_threshold <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // clustered boxes: mostly jittered copies of the previous box
    task automatic offer_frame(input int n);
        logic [15:0] ox;
        logic [15:0] oy;
        logic [15:0] pl;
        logic [15:0] pt;
        logic [15:0] pw;
        logic [15:0] ph;
        logic [15:0] l;
        logic [15:0] t;
        logic [15:0] w;
        logic [15:0] h;
        logic        fs;
        int          pick;
        ox = 16'($urandom);
        oy = 16'($urandom);
        pl = ox;
        pt = oy;
        pw = 16'($urandom_range(1, 4095));
        ph = 16'($urandom_range(1, 4095));
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            fs   = (k == 0) ? ($urandom_range(0, 9) != 0) : 1'b0;
            if (pick < 55)
            begin
                l = pl + 16'($urandom_range(0, pw / 4 + 1)) - pw / 8;
                t = pt + 16'($urandom_range(0, ph / 4 + 1)) - ph / 8;
                w = pw + 16'($urandom_range(0, pw / 4 + 1)) - pw / 8;
                h = ph + 16'($urandom_range(0, ph / 4 + 1)) - ph / 8;
            end
            else if (pick < 80)
            begin
                l = ox + 16'($urandom_range(0, 4095));
                t = oy + 16'($urandom_range(0, 4095));
                w = 16'($urandom_range(0, 4095));
                h = 16'($urandom_range(0, 4095));
            end
            else if (pick < 90)
            begin
                l = 16'($urandom);
                t = 16'($urandom);
                w = 16'($urandom);
                h = 16'($urandom);
            end
            else if (pick < 95)
            begin
                l = pl + 16'($urandom_range(0, 63));
                t = pt + 16'($urandom_range(0, 63));
                w = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
                h = (w == 0) ? 16'($urandom) : 16'd0;
            end
            else
            begin
                fs = 1'b1;
                l  = 16'($urandom);
                t  = 16'($urandom);
                w  = 16'($urandom_range(0, 8191));
                h  = 16'($urandom_range(0, 8191));
            end
            offer_box(fs, l, t, w, h);
            if (w != 0 && h != 0)
            begin
                pl = l;
                pt = t;
                pw = w;
                ph = h;
            end
        end
    endtask

    // disjoint grid boxes, more than the table holds
    task automatic offer_full_frame;
        for (int slot = 0; slot < 76; slot++)
            offer_box(slot == 0,
                      16'((slot % 9) * 7200 + $urandom_range(0, 99)),
                      16'((slot / 9) * 7200 + $urandom_range(0, 99)),
                      16'($urandom_range(0, 7000)),
                      16'($urandom_range(0, 7000)));
    endtask

    task automatic run_random(input int count);
        int target;
        target = boxes_sent + count;
        offer_full_frame();
        while (boxes_sent < target)
            offer_frame($urandom_range(1, 24));
    endtask

    initial
    begin
        send_idle_pct = 36;
        recv_idle_pct = 66;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_box(1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
        offer_box(1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
        offer_box(1'b0, 16'd0, 16'd0, 16'd16, 16'd0);
        offer_box(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        offer_box(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        offer_box(1'b0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        offer_box(1'b0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
        offer_box(1'b1, 16'd100, 16'd100, 16'd200, 16'd200);
        offer_box(1'b0, 16'd100, 16'd100, 16'd200, 16'd200);
        offer_box(1'b0, 16'd300, 16'd100, 16'd200, 16'd200);
        offer_box(1'b0, 16'd150, 16'd100, 16'd200, 16'd200);
        offer_box(1'b0, 16'd250, 16'd100, 16'd100, 16'd200);
        offer_box(1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
        offer_box(1'b0, 16'd40000, 16'd123, 16'd1, 16'd1);
        offer_box(1'b0, 16'd40000, 16'd123, 16'd1, 16'd1);
        wait_all_results();
        set_threshold(16'd0);
        offer_box(1'b1, 16'd1000, 16'd1000, 16'd100, 16'd100);
        offer_box(1'b0, 16'd1099, 16'd1099, 16'd100, 16'd100);
        offer_box(1'b0, 16'd1100, 16'd1000, 16'd100, 16'd100);
        wait_all_results();
        set_threshold(16'hFFFF);
        offer_box(1'b1, 16'd5000, 16'd5000, 16'd300, 16'd300);
        offer_box(1'b0, 16'd5000, 16'd5000, 16'd300, 16'd300);
        offer_box(1'b0, 16'd5001, 16'd5000, 16'd300, 16'd300);
        offer_box(1'b1, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
        offer_box(1'b0, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);

        wait_all_results();
        set_threshold(16'($urandom));
        run_random(200);

        wait_all_results();
        send_idle_pct = 66;
        recv_idle_pct = 36;
        set_threshold(16'd13107);
        run_random(200);

        wait_all_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_threshold(16'($urandom));
        run_random(190);
        hold_reqs <= hold_reqs + 1;
        offer_frame(16);

        wait_all_results();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
